/* rtl/core/xxh32_pkg.sv */
// shared types and constants of the xxhash32 stream hasher
`timescale 1ns / 1ps
package xxh32_pkg;

    localparam logic [31:0] P1         = 32'd2654435761;
    localparam logic [31:0] P2         = 32'd2246822519;
    localparam logic [31:0] P3         = 32'd3266489917;
    localparam logic [31:0] P4         = 32'd668265265;
    localparam logic [31:0] P5         = 32'd374761393;
    localparam logic [31:0] SEED_RESET = 32'hDEADBEEF;

    // classified message word as it travels from front to back
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  cnt;    // effective byte count, 0..4
        logic        last;
        logic        first;  // opens a new message
    } t_item;

    // head of the queue as seen by the back end
    typedef struct packed {
        t_item item;
        logic  empty;
    } t_q_head;

endpackage

/* rtl/core/xxh32_stream_hasher_unit.sv */
// finish: once the last beat is taken, a full last word first gets its lane round; then the back
// end merges the lanes, runs a tail round per buffered word and per tail byte, then the avalanche
// the back end pops a new message word only after the lane round of the previous one, whose
// multiplies use the shared 32x32 multiplier; tail rounds and avalanche run on it as well
// reset: synchronous active low; clears control, queue and output valid; seed returns to DEADBEEF
`timescale 1ns / 1ps
module xxhash32_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    // hash beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value,
    // seed register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import xxh32_pkg::*;

    // seed register, sampled by the back end when a message opens
    logic [31:0] r_seed;

    // front to queue
    logic    q_push;
    logic    q_full;
    t_item   q_item;

    // queue to back
    logic    q_pop;
    t_q_head q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    // front end: clamps byte counts and marks the first word of each message
    xxh32_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_item       (q_item)
    );

    // decoupling queue, lets input keep flowing while a message finishes
    xxh32_queue #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // back end: lane rounds per word, then merge, tail and avalanche
    xxh32_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

/* rtl/core/xxh32_front.sv */
// front end: accepts input beats and classifies them into queue items
`timescale 1ns / 1ps
module xxh32_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_byte_count,
    input  logic                 i_last,
    input  logic                 i_q_full,
    output logic                 o_push,
    output xxh32_pkg::t_item     o_item
);
    import xxh32_pkg::*;

    logic r_in_msg;
    logic [2:0] cnt_eff;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // non-last words are always full, counts above four clamp to four
    always_comb begin
        if (!i_last || i_byte_count > 3'd4) begin
            cnt_eff = 3'd4;
        end else begin
            cnt_eff = i_byte_count;
        end
    end

    assign o_item.data  = i_data_word;
    assign o_item.cnt   = cnt_eff;
    assign o_item.last  = i_last;
    assign o_item.first = !r_in_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else if (o_push) begin
            r_in_msg <= !i_last;
        end
    end

endmodule

/* rtl/core/xxh32_queue.sv */
// small register queue between front and back end
`timescale 1ns / 1ps
module xxh32_queue #(
    parameter int QDEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  xxh32_pkg::t_item     i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output xxh32_pkg::t_q_head   o_head
);
    import xxh32_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_item          r_mem [QDEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(QDEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    assign o_full       = (r_count == CW'(QDEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_head.empty))
        else $error("queue pop while empty");
`endif

endmodule

/* rtl/core/xxh32_back.sv */
// back end: lane rounds, merge, tail rounds and avalanche; rounds and avalanche share one multiplier
`timescale 1ns / 1ps
module xxh32_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_seed,
    input  xxh32_pkg::t_q_head   i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_hash_value
);
    import xxh32_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_W2   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_T1   = 4'd4;
    localparam logic [3:0] S_T2   = 4'd5;
    localparam logic [3:0] S_B1   = 4'd6;
    localparam logic [3:0] S_B2   = 4'd7;
    localparam logic [3:0] S_A1   = 4'd8;
    localparam logic [3:0] S_A2   = 4'd9;
    localparam logic [3:0] S_A3   = 4'd10;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [31:0] r_lane [4];
    logic [31:0] r_pend [3];
    logic [31:0] r_stripe [3];
    logic [1:0]  r_fill;
    logic        r_done;
    logic [31:0] r_len;
    logic [31:0] r_msg_seed;
    logic [31:0] r_word;
    logic        r_last;
    logic [1:0]  r_tail;
    logic [1:0]  r_idx;
    logic [31:0] r_prod;
    logic [31:0] r_h;
    logic        r_out_valid;
    logic [31:0] r_hash;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_lo;
    logic        is_word;
    logic        out_free;
    logic [1:0]  idx_inc;
    logic [31:0] len_base;
    logic [7:0]  byte_sel;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    assign is_word  = !i_head.item.last || (i_head.item.cnt == 3'd4);
    assign o_pop    = (r_state == S_IDLE) && !i_head.empty;
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + 2'd1;
    assign len_base = i_head.item.first ? 32'd0 : r_len;
    assign byte_sel = r_word[{r_idx, 3'b000} +: 8];

    // operand select of the shared multiplier
    always_comb begin
        mul_a = i_head.item.data;
        mul_b = P2;
        unique case (r_state)
            S_IDLE: begin
                mul_a = i_head.item.data;
                mul_b = P2;
            end
            S_W2: begin
                mul_a = rotl(r_lane[r_fill] + r_prod, 13);
                mul_b = P1;
            end
            S_T1: begin
                mul_a = r_stripe[r_idx];
                mul_b = P3;
            end
            S_T2: begin
                mul_a = rotl(r_h, 17);
                mul_b = P4;
            end
            S_B1: begin
                mul_a = {24'd0, byte_sel};
                mul_b = P5;
            end
            S_B2: begin
                mul_a = rotl(r_h, 11);
                mul_b = P1;
            end
            S_A1: begin
                mul_a = r_h ^ (r_h >> 15);
                mul_b = P2;
            end
            S_A2: begin
                mul_a = r_h ^ (r_h >> 13);
                mul_b = P3;
            end
            default: begin
                mul_a = r_h;
                mul_b = P1;
            end
        endcase
    end

    assign mul_lo = 32'(mul_a * mul_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_head.empty) begin
                    n_state = is_word ? S_W2 : S_M1;
                end
            end
            S_W2: n_state = r_last ? S_M1 : S_IDLE;
            S_M1: n_state = S_M2;
            S_M2: begin
                if (r_fill != 2'd0) begin
                    n_state = S_T1;
                end else if (r_tail != 2'd0) begin
                    n_state = S_B1;
                end else begin
                    n_state = S_A1;
                end
            end
            S_T1: n_state = S_T2;
            S_T2: begin
                if (idx_inc < r_fill) begin
                    n_state = S_T1;
                end else if (r_tail != 2'd0) begin
                    n_state = S_B1;
                end else begin
                    n_state = S_A1;
                end
            end
            S_B1: n_state = S_B2;
            S_B2: n_state = (idx_inc < r_tail) ? S_B1 : S_A1;
            S_A1: n_state = S_A2;
            S_A2: n_state = S_A3;
            S_A3: n_state = out_free ? S_IDLE : S_A3;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 2'd0;
            r_done      <= 1'b0;
            r_len       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_len <= len_base + {29'd0, i_head.item.cnt};
                if (i_head.item.first) begin
                    r_fill <= 2'd0;
                    r_done <= 1'b0;
                end
            end
            if (r_state == S_W2) begin
                if (r_fill == 2'd3) begin
                    r_fill <= 2'd0;
                    r_done <= 1'b1;
                end else begin
                    r_fill <= r_fill + 2'd1;
                end
            end
            if (r_state == S_A3 && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head.item.data;
            r_last <= i_head.item.last;
            r_tail <= is_word ? 2'd0 : i_head.item.cnt[1:0];
            r_prod <= mul_lo;
            if (i_head.item.first) begin
                r_msg_seed <= i_seed;
                r_lane[0]  <= i_seed + P1 + P2;
                r_lane[1]  <= i_seed + P2;
                r_lane[2]  <= i_seed;
                r_lane[3]  <= i_seed - P1;
            end
        end
        unique case (r_state)
            S_W2: begin
                // lanes 0..2 are committed only once the stripe is whole
                if (r_fill == 2'd3) begin
                    r_lane[0] <= r_pend[0];
                    r_lane[1] <= r_pend[1];
                    r_lane[2] <= r_pend[2];
                    r_lane[3] <= mul_lo;
                end else begin
                    r_pend[r_fill]   <= mul_lo;
                    r_stripe[r_fill] <= r_word;
                end
            end
            S_M1: begin
                r_idx <= 2'd0;
                if (r_done) begin
                    r_h <= rotl(r_lane[0], 1) + rotl(r_lane[1], 7);
                end else begin
                    r_h <= r_msg_seed + P5;
                end
            end
            S_M2: begin
                if (r_done) begin
                    r_h <= r_h + rotl(r_lane[2], 12) + rotl(r_lane[3], 18) + r_len;
                end else begin
                    r_h <= r_h + r_len;
                end
            end
            S_T1, S_B1: r_h <= r_h + mul_lo;
            S_T2: begin
                r_h   <= mul_lo;
                r_idx <= (idx_inc < r_fill) ? idx_inc : 2'd0;
            end
            S_B2: begin
                r_h   <= mul_lo;
                r_idx <= idx_inc;
            end
            S_A1, S_A2: r_h <= mul_lo;
            S_A3: begin
                if (out_free) begin
                    r_hash <= r_h ^ (r_h >> 16);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

`ifndef SYNTHESIS
    a_w2_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W2) |-> ($past(r_state) == S_IDLE))
        else $error("lane round second step without a popped word");
    a_tail_word_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1) |-> (r_idx < r_fill))
        else $error("tail word index beyond stripe fill");
    a_tail_byte_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B1) |-> (r_idx < r_tail))
        else $error("tail byte index beyond byte count");
`endif

endmodule
